FILE: rtl/fcls_pkg.sv
package fcls_pkg;

   // Default geometry
   localparam int PAGE_BYTES_DEF   = 256;
   localparam int SECTOR_BYTES_DEF = 4096;
   localparam int ADDR_BITS_DEF    = 24;

   // Fixed field widths
   localparam int CFG_ADDR_W = 24;
   localparam int LEN_W      = 16;
   localparam int PLEN_W     = 8;
   localparam int PAGE_W     = 16;
   localparam int CNT_W      = 32;

   // Register reset values
   localparam logic [CFG_ADDR_W-1:0] LOG_START_RST = 24'h001000;
   localparam logic [CFG_ADDR_W-1:0] LOG_END_RST   = 24'h0FF000;

   typedef enum logic [1:0] {
      FUNC_APPEND     = 2'd0,
      FUNC_ERASE_DONE = 2'd1,
      FUNC_PROG_DONE  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ACT_ERASE      = 3'd0,
      ACT_PROGRAM    = 3'd1,
      ACT_DONE       = 3'd2,
      ACT_BADLEN     = 3'd3,
      ACT_FAIL       = 3'd4,
      ACT_UNEXPECTED = 3'd5
   } action_type;

   typedef enum logic [0:0] {
      CSR_LOG_START = 1'b0,
      CSR_LOG_END   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ERASE = 3'b010,
      PH_PROG  = 3'b100
   } phase_type;

   typedef struct packed {
      func_type          func;
      logic [LEN_W-1:0]  record_len;
      logic              op_ok;
   } item_type;

   typedef struct packed {
      action_type             action;
      logic [CFG_ADDR_W-1:0]  flash_addr;
      logic [PLEN_W-1:0]      program_len;
      logic [PAGE_W-1:0]      page_count;
      logic [CNT_W-1:0]       entries_written;
      logic [CNT_W-1:0]       wraps_done;
   } result_type;

endpackage

FILE: rtl/fcls_engine.sv
module fcls_engine #(
   parameter int PAGE_BYTES   = fcls_pkg::PAGE_BYTES_DEF,
   parameter int SECTOR_BYTES = fcls_pkg::SECTOR_BYTES_DEF,
   parameter int ADDR_BITS    = fcls_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  fcls_pkg::item_type                   item,
   input  logic [fcls_pkg::CFG_ADDR_W-1:0]      log_start,
   input  logic [fcls_pkg::CFG_ADDR_W-1:0]      log_end,
   output fcls_pkg::result_type                 result
);
   import fcls_pkg::*;

   localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   // sum width: covers start + shifted index, and address + page without wrap
   localparam int SW_A = CFG_ADDR_W + 1;
   localparam int SW_B = PAGE_W + PAGE_SHIFT + 1;
   localparam int SW_C = ADDR_BITS + 1;
   localparam int SW_AB = (SW_A > SW_B) ? SW_A : SW_B;
   localparam int SW = (SW_AB > SW_C) ? SW_AB : SW_C;

   phase_type              phase_ff, phase_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [CNT_W-1:0]       entry_ff, entry_in;
   logic [CNT_W-1:0]       wrap_ff, wrap_in;
   logic [PLEN_W-1:0]      pend_len_ff, pend_len_in;
   logic [ADDR_BITS-1:0]   pend_addr_ff, pend_addr_in;

   logic                   len_bad;
   logic [SW-1:0]          addr_sum;
   logic [ADDR_BITS-1:0]   new_addr;
   logic [SW-1:0]          new_addr_ext;
   logic [SW-1:0]          pend_addr_ext;
   logic                   aligned;
   logic                   end_hit;
   action_type             act;
   logic [CFG_ADDR_W-1:0]  act_addr;
   logic [PLEN_W-1:0]      act_len;

   assign len_bad = (item.record_len == '0) ||
                    (item.record_len > LEN_W'(PAGE_BYTES - 4));
   assign addr_sum = SW'(log_start) + (SW'(page_ff) << PAGE_SHIFT);
   assign new_addr = addr_sum[ADDR_BITS-1:0];
   assign new_addr_ext = SW'(new_addr);
   assign pend_addr_ext = SW'(pend_addr_ff);
   assign aligned = (new_addr[SECTOR_SHIFT-1:0] == '0);
   assign end_hit = (pend_addr_ext + SW'(PAGE_BYTES)) >= SW'(log_end);

   always_comb begin
      phase_in     = phase_ff;
      page_in      = page_ff;
      entry_in     = entry_ff;
      wrap_in      = wrap_ff;
      pend_len_in  = pend_len_ff;
      pend_addr_in = pend_addr_ff;
      act          = ACT_UNEXPECTED;
      act_addr     = '0;
      act_len      = '0;
      unique case (item.func)
         FUNC_APPEND: begin
            if (phase_ff == PH_IDLE) begin
               if (len_bad) begin
                  act = ACT_BADLEN;
               end else begin
                  pend_addr_in = new_addr;
                  pend_len_in  = item.record_len[PLEN_W-1:0];
                  act_addr     = new_addr_ext[CFG_ADDR_W-1:0];
                  if (aligned) begin
                     phase_in = PH_ERASE;
                     act      = ACT_ERASE;
                  end else begin
                     phase_in = PH_PROG;
                     act      = ACT_PROGRAM;
                     act_len  = item.record_len[PLEN_W-1:0];
                  end
               end
            end
         end
         FUNC_ERASE_DONE: begin
            if (phase_ff == PH_ERASE) begin
               if (item.op_ok) begin
                  phase_in = PH_PROG;
                  act      = ACT_PROGRAM;
                  act_addr = pend_addr_ext[CFG_ADDR_W-1:0];
                  act_len  = pend_len_ff;
               end else begin
                  phase_in = PH_IDLE;
                  act      = ACT_FAIL;
               end
            end
         end
         FUNC_PROG_DONE: begin
            if (phase_ff == PH_PROG) begin
               phase_in = PH_IDLE;
               if (item.op_ok) begin
                  act      = ACT_DONE;
                  entry_in = entry_ff + 1'b1;
                  if (end_hit) begin
                     page_in = '0;
                     wrap_in = wrap_ff + 1'b1;
                  end else begin
                     page_in = page_ff + 1'b1;
                  end
               end else begin
                  act = ACT_FAIL;
               end
            end
         end
         default: begin
            act = ACT_UNEXPECTED;
         end
      endcase
   end

   assign result.action          = act;
   assign result.flash_addr      = act_addr;
   assign result.program_len     = act_len;
   assign result.page_count      = page_in;
   assign result.entries_written = entry_in;
   assign result.wraps_done      = wrap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         page_ff      <= '0;
         entry_ff     <= '0;
         wrap_ff      <= '0;
         pend_len_ff  <= '0;
         pend_addr_ff <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         page_ff      <= page_in;
         entry_ff     <= entry_in;
         wrap_ff      <= wrap_in;
         pend_len_ff  <= pend_len_in;
         pend_addr_ff <= pend_addr_in;
      end
   end

endmodule

FILE: rtl/flash_circular_log_sequencer_core.sv
// Append sequencer for a page-per-record circular log in NOR flash. Each
// request transfer (append request, erase report or program report) yields
// exactly one response transfer telling the flash driver what to do next:
// erase a sector, program a page, or report done, bad length, flash failure
// or an out-of-order event. Throughput is one transfer per clock unless the
// response side stalls; a request passes the input register, then the state
// update and result register. The step logic is an add of the page offset
// and an address add and compare, so only the response stall limits the rate.
// PAGE_BYTES and SECTOR_BYTES must be powers of two. The user must write the
// two csr address registers only while no append is in flight (unenforced).
module flash_circular_log_sequencer_core #(
   parameter int PAGE_BYTES   = fcls_pkg::PAGE_BYTES_DEF,
   parameter int SECTOR_BYTES = fcls_pkg::SECTOR_BYTES_DEF,
   parameter int ADDR_BITS    = fcls_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fcls_pkg::func_type                   req_func,
   input  logic [fcls_pkg::LEN_W-1:0]           req_record_len,
   input  logic                                 req_op_ok,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fcls_pkg::action_type                 rsp_action,
   output logic [fcls_pkg::CFG_ADDR_W-1:0]      rsp_flash_addr,
   output logic [fcls_pkg::PLEN_W-1:0]          rsp_program_len,
   output logic [fcls_pkg::PAGE_W-1:0]          rsp_page_count,
   output logic [fcls_pkg::CNT_W-1:0]           rsp_entries_written,
   output logic [fcls_pkg::CNT_W-1:0]           rsp_wraps_done,
   // register write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  fcls_pkg::csr_index_type              csr_index,
   input  logic [fcls_pkg::CFG_ADDR_W-1:0]      csr_wdata
);
   import fcls_pkg::*;

   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   // config registers
   logic [CFG_ADDR_W-1:0]  log_start_ff;
   logic [CFG_ADDR_W-1:0]  log_end_ff;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   item_type               in_item_ff;
   logic                   req_take;

   // result stage
   logic                   out_valid_ff, out_valid_in;
   result_type             out_res_ff;
   result_type             step_res;
   logic                   step_fire;

   // Item moves from the input stage into the result register when that
   // register is empty or its transfer completes this cycle.
   assign step_fire   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !step_fire;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step_fire);
   assign out_valid_in = step_fire || (out_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_start_ff <= LOG_START_RST;
         log_end_ff   <= LOG_END_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOG_START: log_start_ff <= csr_wdata;
            CSR_LOG_END:   log_end_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func       <= req_func;
         in_item_ff.record_len <= req_record_len;
         in_item_ff.op_ok      <= req_op_ok;
      end
      if (step_fire) begin
         out_res_ff <= step_res;
      end
   end

   // phase, page index, counters and the pending command live here
   fcls_engine #(
      .PAGE_BYTES   (PAGE_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_fire),
      .item      (in_item_ff),
      .log_start (log_start_ff),
      .log_end   (log_end_ff),
      .result    (step_res)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = out_res_ff.action;
   assign rsp_flash_addr      = out_res_ff.flash_addr;
   assign rsp_program_len     = out_res_ff.program_len;
   assign rsp_page_count      = out_res_ff.page_count;
   assign rsp_entries_written = out_res_ff.entries_written;
   assign rsp_wraps_done      = out_res_ff.wraps_done;

   // stall only back-pressures when an item is actually held
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input stage");

   // an erase command always targets a sector boundary
   a_erase_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_ERASE)) |->
         (rsp_flash_addr[SECTOR_SHIFT-1:0] == '0))
      else $error("erase address not sector aligned");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule
